FILE: rtl/core/aps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants of the anemometer period speed unit
// Widths, register indexes, reset values, controller states and the
// structs that pass between the timebase, the divider and the top level.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W  = $clog2(SPEED_W);

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    localparam logic [TIME_W-1:0]  TIMEOUT_RST = TIME_W'(1000000);
    localparam logic [TIME_W-1:0]  UPDATE_RST  = TIME_W'(500000);
    localparam logic [SPEED_W-1:0] SCALE_RST   = SPEED_W'(8750000);

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic              report;
        logic              calm;
        logic              fresh;
        logic [TIME_W-1:0] period;
    } tick_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/core/aps_timebase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_timebase: tick bookkeeping
// Tracks time since the last edge and since the last report, the period
// between edges, the calm state and the fresh-period flag, one tick per request.
// ----------------------------------------------------------------------------
module aps_timebase
    import aps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_en,
    input  logic              edge_req,
    input  logic [TIME_W-1:0] timeout_us,
    input  logic [TIME_W-1:0] update_us,
    output tick_t             tick
);

    logic [TIME_W-1:0] age_edge_reg;
    logic [TIME_W-1:0] age_edge_next;
    logic [TIME_W-1:0] age_rep_reg;
    logic [TIME_W-1:0] age_rep_next;
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] period_next;
    logic              waiting_reg;
    logic              waiting_next;
    logic              ready_reg;
    logic              ready_next;

    logic [TIME_W-1:0] since_edge;
    logic              wait_edge;
    logic              ready_edge;
    logic              report;
    logic              fresh;

    always_comb
    begin
        since_edge  = age_edge_reg;
        wait_edge   = waiting_reg;
        ready_edge  = ready_reg;
        period_next = period_reg;
        if (edge_req)
        begin
            since_edge = '0;
            if (waiting_reg)
            begin
                wait_edge = 1'b0;
            end
            else
            begin
                period_next = age_edge_reg;
                ready_edge  = 1'b1;
            end
        end

        waiting_next = wait_edge;
        if (!wait_edge && (since_edge > timeout_us))
        begin
            waiting_next = 1'b1;
        end

        report = (age_rep_reg >= update_us);
        fresh  = report && !waiting_next && ready_edge;

        ready_next    = fresh ? 1'b0 : ready_edge;
        age_edge_next = since_edge + TIME_W'(1);
        age_rep_next  = report ? TIME_W'(1) : age_rep_reg + TIME_W'(1);
    end

    assign tick.report = report;
    assign tick.calm   = waiting_next;
    assign tick.fresh  = fresh;
    assign tick.period = period_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_edge_reg <= '0;
            age_rep_reg  <= '0;
            period_reg   <= '0;
            waiting_reg  <= 1'b1;
            ready_reg    <= 1'b0;
        end
        else if (tick_en)
        begin
            age_edge_reg <= age_edge_next;
            age_rep_reg  <= age_rep_next;
            period_reg   <= period_next;
            waiting_reg  <= waiting_next;
            ready_reg    <= ready_next;
        end
    end

endmodule

FILE: rtl/core/aps_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_divider: bit-serial restoring divider
// Divides the speed scale by the period, one quotient bit per cycle,
// shifting dividend bits out and quotient bits in through one register.
// ----------------------------------------------------------------------------
module aps_divider
    import aps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SPEED_W-1:0] dividend,
    input  logic [TIME_W-1:0]  divisor,
    output div_stat_t          stat,
    output logic [SPEED_W-1:0] quotient
);

    logic [SPEED_W-1:0]   dq_reg;
    logic [SPEED_W-1:0]   dq_next;
    logic [SPEED_W-1:0]   rem_reg;
    logic [SPEED_W-1:0]   rem_next;
    logic [TIME_W-1:0]    divisor_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;

    logic [SPEED_W-1:0]   partial;
    logic                 fits;

    always_comb
    begin
        partial = {rem_reg[SPEED_W-2:0], dq_reg[SPEED_W-1]};
        fits    = ({{(TIME_W-SPEED_W){1'b0}}, partial} >= divisor_reg);

        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[SPEED_W-2:0], fits};
            rem_next = fits ? partial - divisor_reg[SPEED_W-1:0] : partial;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(SPEED_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;

endmodule

FILE: rtl/core/anemometer_period_speed_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anemometer_period_speed_unit: pulse period wind speed meter
// Takes one microsecond tick per request, measures the edge period, enters
// calm after a timeout and reports a speed every update interval.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------
//   in       | in_valid / in_ready  | edge_req
//   out      | out_valid / out_ready| speed, calm
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A tick without a report leaves the controller idle. A report passes the
// load state, first the divide state when a fresh period is divided: the
// serial divider makes one quotient bit per cycle. The output register lets
// the next tick enter while a report waits; a full output register stalls
// a new report in the load state. Reset restores register defaults and calm.
// ----------------------------------------------------------------------------
module anemometer_period_speed_unit
    import aps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  edge_req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SPEED_W-1:0]    speed,
    output logic                  calm,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_state_t        state_reg;
    ctrl_state_t        state_next;

    logic [TIME_W-1:0]  timeout_reg;
    logic [TIME_W-1:0]  update_reg;
    logic [SPEED_W-1:0] scale_reg;
    logic [SPEED_W-1:0] held_reg;
    logic [SPEED_W-1:0] held_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [SPEED_W-1:0] speed_reg;
    logic               calm_out_reg;
    logic               calm_reg;
    logic               calm_next;

    tick_t              tick;
    div_stat_t          div_stat;
    logic [SPEED_W-1:0] quotient;

    logic               accept;
    logic               div_start;
    logic               out_load;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    aps_timebase u_timebase (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (accept),
        .edge_req   (edge_req),
        .timeout_us (timeout_reg),
        .update_us  (update_reg),
        .tick       (tick)
    );

    aps_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scale_reg),
        .divisor  (tick.period),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && tick.report)
                begin
                    if (!tick.calm && tick.fresh && (tick.period != '0))
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                div_start = in_valid && tick.report && !tick.calm && tick.fresh &&
                            (tick.period != '0);
            end
            ST_DIV:
            begin
            end
            ST_LOAD:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        held_next = held_reg;
        calm_next = calm_reg;
        if (accept && tick.report)
        begin
            calm_next = tick.calm;
            if (tick.calm)
            begin
                held_next = '0;
            end
            else if (tick.fresh && (tick.period == '0))
            begin
                held_next = SPEED_MAX;
            end
        end
        else if ((state_reg == ST_DIV) && div_stat.done)
        begin
            held_next = quotient;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timeout_reg   <= TIMEOUT_RST;
            update_reg    <= UPDATE_RST;
            scale_reg     <= SCALE_RST;
            held_reg      <= '0;
            calm_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            calm_reg      <= calm_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIMEOUT: timeout_reg <= cfg_data;
                    CFG_UPDATE:  update_reg  <= cfg_data;
                    CFG_SCALE:   scale_reg   <= cfg_data[SPEED_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            speed_reg    <= held_reg;
            calm_out_reg <= calm_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign speed     = speed_reg;
    assign calm      = calm_out_reg;

    a_start_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> accept)
        else $error("divider started without an accepted request");

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !in_ready)
        else $error("input ready while divider busy");

    a_calm_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && calm) |-> (speed == '0))
        else $error("calm report with nonzero speed");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider result outside divide state");

endmodule

FILE: dv/anemometer_period_speed_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anemometer_period_speed_unit_test: self-checking bench for the wind meter
// Streams microsecond ticks with directed and random edge patterns under
// several register settings, predicts every speed report in step with the
// accepted ticks and compares speed and calm with what the unit reports.
// ----------------------------------------------------------------------------
module anemometer_period_speed_unit_test;
    import aps_pkg::*;

    localparam int HALF_NS       = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int SEGMENTS      = 9;
    localparam int SEG_TICKS     = 115;
    localparam longint LIMIT_NS  = 64'd8_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               calm;
    } report_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  edge_req  = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SPEED_W-1:0]    speed;
    logic                  calm;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TIMEOUT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [TIME_W-1:0]  cfg_timeout = TIMEOUT_RST;
    logic [TIME_W-1:0]  cfg_update  = UPDATE_RST;
    logic [SPEED_W-1:0] cfg_scale   = SCALE_RST;

    logic [TIME_W-1:0]  tick_us       = '0;
    logic [TIME_W-1:0]  edge_us       = '0;
    logic [TIME_W-1:0]  period_us     = '0;
    logic [TIME_W-1:0]  report_us     = '0;
    logic               awaiting_edge = 1'b1;
    logic               period_fresh  = 1'b0;
    logic [SPEED_W-1:0] held_speed    = '0;

    report_t reports_due[$];
    logic    pending_edges[$];

    int   ticks_queued  = 0;
    int   ticks_taken   = 0;
    int   errors        = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_asked    = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;
    logic in_taken      = 1'b0;

    anemometer_period_speed_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .edge_req  (edge_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .speed     (speed),
        .calm      (calm),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_NS) clk = ~clk;

    function automatic void meter_tick(input logic edge_seen);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] quotient;
        report_t           rep;
        t = tick_us;
        if (edge_seen)
        begin
            if (awaiting_edge)
            begin
                awaiting_edge = 1'b0;
            end
            else
            begin
                period_us    = t - edge_us;
                period_fresh = 1'b1;
            end
            edge_us = t;
        end
        if (!awaiting_edge && TIME_W'(t - edge_us) > cfg_timeout)
        begin
            awaiting_edge = 1'b1;
        end
        if (TIME_W'(t - report_us) >= cfg_update)
        begin
            report_us = t;
            if (awaiting_edge)
            begin
                held_speed = '0;
            end
            else if (period_fresh)
            begin
                period_fresh = 1'b0;
                if (period_us == '0)
                begin
                    held_speed = SPEED_MAX;
                end
                else
                begin
                    quotient   = TIME_W'(cfg_scale) / period_us;
                    held_speed = (quotient > TIME_W'(SPEED_MAX)) ? SPEED_MAX
                                                                 : quotient[SPEED_W-1:0];
                end
            end
            rep.speed = held_speed;
            rep.calm  = awaiting_edge;
            reports_due.push_back(rep);
        end
        tick_us = t + 1'b1;
    endfunction

    // drive tick requests
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (pending_edges.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                edge_req <= pending_edges.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // throttle the report channel
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        report_t want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIMEOUT: cfg_timeout = cfg_data;
                    CFG_UPDATE:  cfg_update  = cfg_data;
                    CFG_SCALE:   cfg_scale   = cfg_data[SPEED_W-1:0];
                    default:     ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                meter_tick(edge_req);
                ticks_taken = ticks_taken + 1;
            end
            if (out_valid && out_ready)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("unexpected report: speed %0d calm %0d", speed, calm);
                    errors = errors + 1;
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (speed !== want.speed)
                    begin
                        $error("speed: expected %0d, actual %0d", want.speed, speed);
                        errors = errors + 1;
                    end
                    if (calm !== want.calm)
                    begin
                        $error("calm: expected %0d, actual %0d", want.calm, calm);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // queue ticks, lowest pattern bit first
    task automatic offer(input logic [31:0] pattern, input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            pending_edges.push_back(pattern[i]);
        end
        ticks_queued = ticks_queued + count;
    endtask

    task automatic drain();
        while (pending_edges.size() != 0 || ticks_taken != ticks_queued ||
               reports_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                    seg;
        int                    n;
        int                    k;
        logic [TIME_W-1:0]     tmo;
        logic [TIME_W-1:0]     upd;
        logic [CFG_DATA_W-1:0] scl;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: no report this early
        offer(32'b101, 3);
        drain();

        // period of one tick saturates, then a gap beyond the timeout
        write_reg(CFG_TIMEOUT, 32'd2);
        write_reg(CFG_UPDATE, 32'd0);
        write_reg(CFG_SCALE, CFG_DATA_W'(SPEED_MAX));
        offer(32'b0110_0011, 8);
        drain();

        // zero timeout and zero scale
        write_reg(CFG_TIMEOUT, 32'd0);
        write_reg(CFG_UPDATE, 32'd2);
        write_reg(CFG_SCALE, 32'd0);
        offer(32'b001_0111, 7);
        drain();

        // widest values, upper scale bits dropped, spare index ignored
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_UPDATE, 32'hFFFF_FFFF);
        write_reg(CFG_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        offer(32'b101, 3);
        drain();

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle_pct = (seg < 3) ? 31 : (seg < 6) ? 49 : 0;
            recv_idle_pct = (seg < 3) ? 49 : (seg < 6) ? 31 : 0;
            tmo = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 60);
            upd = (seg == 1) ? '0 : $urandom_range(0, 12);
            scl = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
            write_reg(CFG_TIMEOUT, tmo);
            write_reg(CFG_UPDATE, upd);
            write_reg(CFG_SCALE, scl);
            if (seg == 1)
            begin
                hold_asked = hold_asked + 1;
            end
            k = $urandom_range(1, 12);
            n = 0;
            while (n < SEG_TICKS)
            begin
                if (tmo < 64 && $urandom_range(0, 39) == 0)
                begin
                    // quiet stretch: drop back to calm
                    repeat (tmo + 2) offer(32'b0, 1);
                    n = n + int'(tmo) + 2;
                end
                else
                begin
                    offer(32'($urandom_range(1, k) == 1), 1);
                    n = n + 1;
                end
            end
            drain();
        end

        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
